// ===== rtl/core/eq_pkg.sv =====
// Shared constants, types and the half-angle sine table for the Euler to quaternion block.
`timescale 1ns / 1ps
`default_nettype none

package eq_pkg;

  localparam int FracBits   = 14;
  localparam int MaxAngle   = 180;
  localparam int TabBits    = 30;
  localparam int TabLast    = 180;
  localparam int AngleWidth = 8;
  localparam int OutWidth   = 16;
  localparam int TrigWidth  = 32;
  localparam int ProdWidth  = 64;
  localparam int OutShift   = 2 * TabBits - FracBits;

  localparam logic [63:0] PiQ60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] StepQ60 = PiQ60 / 64'd90;

  typedef logic [TabBits:0]                 tab_entry_t;
  typedef tab_entry_t                       sine_tab_t [TabLast+1];
  typedef logic signed [TrigWidth-1:0]      trig_val_t;
  typedef logic signed [ProdWidth-1:0]      prod_t;
  typedef logic signed [OutWidth-1:0]       quat_val_t;

  typedef struct packed {
    trig_val_t sin_v;
    trig_val_t cos_v;
  } trig_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic tab_entry_t sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rounded;
    x    = 64'(k) * StepQ60;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q62(term, x2) / 64'd110; sum = sum - term;
    term = mul_q62(term, x2) / 64'd156; sum = sum + term;
    term = mul_q62(term, x2) / 64'd210; sum = sum - term;
    term = mul_q62(term, x2) / 64'd272; sum = sum + term;
    term = mul_q62(term, x2) / 64'd342; sum = sum - term;
    term = mul_q62(term, x2) / 64'd420; sum = sum + term;
    term = mul_q62(term, x2) / 64'd506; sum = sum - term;
    term = mul_q62(term, x2) / 64'd600; sum = sum + term;
    term = mul_q62(term, x2) / 64'd702; sum = sum - term;
    rounded = (sum + (64'd1 << (61 - TabBits))) >> (62 - TabBits);
    return rounded[TabBits:0];
  endfunction

  function automatic sine_tab_t build_tab();
    sine_tab_t tab;
    for (int unsigned k = 0; k <= TabLast; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_tab();

endpackage

`default_nettype wire

// ===== rtl/core/euler_to_quaternion.sv =====
// Top level of the pipelined Euler angle to quaternion converter.
// The input channel takes roll, pitch and yaw in whole degrees, each
// saturated to 180, under a valid and ready transfer.
// The output channel gives w, x, y and z as signed Q2.14 values under a
// valid and ready transfer; each input gives exactly one result.
// The datapath has five register stages: table lookup, first products,
// rounding to 30 fraction bits, second products, and the final sum with
// rounding to 14 fraction bits.
// Throughput is one item per cycle, set by every stage passing its item
// on in each cycle in which the receiver takes a result.
// Reset empties every stage; nothing is held across it.
// When the receiver stalls, the last stage holds its result and the
// stages behind it fill up; input ready falls only once all five hold an
// item, and no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [eq_pkg::AngleWidth-1:0] roll_degrees,
  input  logic [eq_pkg::AngleWidth-1:0] pitch_degrees,
  input  logic [eq_pkg::AngleWidth-1:0] yaw_degrees,
  output logic                        out_valid,
  input  logic                        out_ready,
  output eq_pkg::quat_val_t           quat_w,
  output eq_pkg::quat_val_t           quat_x,
  output eq_pkg::quat_val_t           quat_y,
  output eq_pkg::quat_val_t           quat_z
);
  import eq_pkg::*;

  localparam prod_t TabHalf = prod_t'(64'sd1 <<< (TabBits - 1));
  localparam prod_t OutHalf = prod_t'(64'sd1 <<< (OutShift - 1));

  trig_t trig_r_in;
  trig_t trig_p_in;
  trig_t trig_y_in;

  logic  v0, v1, v2, v3, v4;
  logic  adv0, adv1, adv2, adv3, adv4;

  trig_t     trig_r, trig_p, trig_y;
  prod_t     p_cc, p_ss, p_sc, p_cs;
  trig_val_t cy1, sy1;
  trig_val_t cc, ss, sc, cs;
  trig_val_t cy2, sy2;
  prod_t     m_cc_cy, m_ss_sy, m_sc_cy, m_cs_sy;
  prod_t     m_cs_cy, m_sc_sy, m_cc_sy, m_ss_cy;
  quat_val_t w_q, x_q, y_q, z_q;

  prod_t sum_w, sum_x, sum_y, sum_z;
  prod_t rnd_cc, rnd_ss, rnd_sc, rnd_cs;

  eq_trig_lookup u_roll  (.angle(roll_degrees),  .trig(trig_r_in));
  eq_trig_lookup u_pitch (.angle(pitch_degrees), .trig(trig_p_in));
  eq_trig_lookup u_yaw   (.angle(yaw_degrees),   .trig(trig_y_in));

  assign adv4     = !v4 || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_comb begin
    rnd_cc = (p_cc + TabHalf) >>> TabBits;
    rnd_ss = (p_ss + TabHalf) >>> TabBits;
    rnd_sc = (p_sc + TabHalf) >>> TabBits;
    rnd_cs = (p_cs + TabHalf) >>> TabBits;
    sum_w  = (m_cc_cy + m_ss_sy + OutHalf) >>> OutShift;
    sum_x  = (m_sc_cy - m_cs_sy + OutHalf) >>> OutShift;
    sum_y  = (m_cs_cy + m_sc_sy + OutHalf) >>> OutShift;
    sum_z  = (m_cc_sy - m_ss_cy + OutHalf) >>> OutShift;
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      trig_r <= trig_r_in;
      trig_p <= trig_p_in;
      trig_y <= trig_y_in;
    end
    if (adv1) begin
      p_cc <= prod_t'(trig_r.cos_v) * prod_t'(trig_p.cos_v);
      p_ss <= prod_t'(trig_r.sin_v) * prod_t'(trig_p.sin_v);
      p_sc <= prod_t'(trig_r.sin_v) * prod_t'(trig_p.cos_v);
      p_cs <= prod_t'(trig_r.cos_v) * prod_t'(trig_p.sin_v);
      cy1  <= trig_y.cos_v;
      sy1  <= trig_y.sin_v;
    end
    if (adv2) begin
      cc  <= rnd_cc[TrigWidth-1:0];
      ss  <= rnd_ss[TrigWidth-1:0];
      sc  <= rnd_sc[TrigWidth-1:0];
      cs  <= rnd_cs[TrigWidth-1:0];
      cy2 <= cy1;
      sy2 <= sy1;
    end
    if (adv3) begin
      m_cc_cy <= prod_t'(cc) * prod_t'(cy2);
      m_ss_sy <= prod_t'(ss) * prod_t'(sy2);
      m_sc_cy <= prod_t'(sc) * prod_t'(cy2);
      m_cs_sy <= prod_t'(cs) * prod_t'(sy2);
      m_cs_cy <= prod_t'(cs) * prod_t'(cy2);
      m_sc_sy <= prod_t'(sc) * prod_t'(sy2);
      m_cc_sy <= prod_t'(cc) * prod_t'(sy2);
      m_ss_cy <= prod_t'(ss) * prod_t'(cy2);
    end
    if (adv4) begin
      w_q <= sum_w[OutWidth-1:0];
      x_q <= sum_x[OutWidth-1:0];
      y_q <= sum_y[OutWidth-1:0];
      z_q <= sum_z[OutWidth-1:0];
    end
  end

  assign out_valid = v4;
  assign quat_w    = w_q;
  assign quat_x    = x_q;
  assign quat_y    = y_q;
  assign quat_z    = z_q;

endmodule

`default_nettype wire

// ===== rtl/core/eq_trig_lookup.sv =====
// Angle saturation and half-angle sine and cosine lookup.
`timescale 1ns / 1ps
`default_nettype none

module eq_trig_lookup (
  input  logic [eq_pkg::AngleWidth-1:0] angle,
  output eq_pkg::trig_t                 trig
);
  import eq_pkg::*;

  localparam logic [AngleWidth-1:0] MaxAngleCode = AngleWidth'(MaxAngle);
  localparam logic [AngleWidth:0]   TabLastCode  = (AngleWidth + 1)'(TabLast);
  localparam logic [AngleWidth:0]   FullTurn     = (AngleWidth + 1)'(2 * TabLast);

  logic [AngleWidth-1:0] clamped;
  logic [AngleWidth:0]   wide;
  logic [AngleWidth:0]   sin_idx;
  logic [AngleWidth:0]   cos_idx;
  tab_entry_t            sin_raw;
  tab_entry_t            cos_raw;
  logic                  upper;

  always_comb begin
    clamped = (angle > MaxAngleCode) ? MaxAngleCode : angle;
    wide    = {1'b0, clamped};
    upper   = wide > TabLastCode;
    if (upper) begin
      sin_idx = FullTurn - wide;
      cos_idx = wide - TabLastCode;
    end else begin
      sin_idx = wide;
      cos_idx = TabLastCode - wide;
    end
    sin_raw = SineTab[sin_idx[AngleWidth-1:0]];
    cos_raw = SineTab[cos_idx[AngleWidth-1:0]];
    trig.sin_v = trig_val_t'({1'b0, sin_raw});
    trig.cos_v = upper ? -trig_val_t'({1'b0, cos_raw}) : trig_val_t'({1'b0, cos_raw});
  end

endmodule

`default_nettype wire

// ===== rtl/core/eq_checker.sv =====
// Port-level checks for the Euler to quaternion block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module eq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  eq_pkg::quat_val_t             quat_w,
  input  eq_pkg::quat_val_t             quat_x,
  input  eq_pkg::quat_val_t             quat_y,
  input  eq_pkg::quat_val_t             quat_z
);
  import eq_pkg::*;

  localparam quat_val_t UnitPos = quat_val_t'(1 <<< FracBits);
  localparam quat_val_t UnitNeg = quat_val_t'(-(1 <<< FracBits));

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("A result was offered straight after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z))
    else $error("A stalled result changed before its transfer.");

  a_ready_flows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("Input was refused although the receiver was taking results.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready [*3] |-> ##2 out_valid)
    else $error("A result did not appear four cycles after its input transfer.");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w >= UnitNeg && quat_w <= UnitPos && quat_x >= UnitNeg
      && quat_x <= UnitPos && quat_y >= UnitNeg && quat_y <= UnitPos
      && quat_z >= UnitNeg && quat_z <= UnitPos)
    else $error("A quaternion component lies outside the unit range.");

endmodule

bind euler_to_quaternion eq_checker u_eq_checker (.*);

`default_nettype wire

// ===== tb/euler_to_quaternion_tb.sv =====
// Self-checking testbench for the Euler angle to quaternion converter.
`timescale 1ns / 1ps

typedef logic [3:0][15:0] quat_t;

class quat_ledger;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam int TopAngle = 180;
  localparam int TabFrac = 30;
  localparam int QuatFrac = 14;

  longint half_step_sine[181];
  quat_t awaited_quats[$];
  int mismatches;

  function new();
    mismatches = 0;
    for (int k = 0; k <= 180; k++) begin
      half_step_sine[k] = series_sine(k);
    end
  endfunction

  function logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Sine of k half-degree steps by a Taylor series held at 62 fraction bits.
  function longint series_sine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = 64'(k) * (PiQ60 / 64'd90);
    x2 = q62_product(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 13; n++) begin
      term = q62_product(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return longint'((sum + (64'd1 << (61 - TabFrac))) >> (62 - TabFrac));
  endfunction

  function longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function quat_t angles_to_quat(logic [7:0] r_deg, logic [7:0] p_deg, logic [7:0] y_deg);
    int r;
    int p;
    int y;
    longint cr, sr, cp, sp, cy, sy;
    longint cc, ss, sc, cs;
    int sh;
    quat_t q;
    r = (r_deg > TopAngle) ? TopAngle : r_deg;
    p = (p_deg > TopAngle) ? TopAngle : p_deg;
    y = (y_deg > TopAngle) ? TopAngle : y_deg;
    sr = half_step_sine[r];
    cr = half_step_sine[180 - r];
    sp = half_step_sine[p];
    cp = half_step_sine[180 - p];
    sy = half_step_sine[y];
    cy = half_step_sine[180 - y];
    cc = round_half_up(cr * cp, TabFrac);
    ss = round_half_up(sr * sp, TabFrac);
    sc = round_half_up(sr * cp, TabFrac);
    cs = round_half_up(cr * sp, TabFrac);
    sh = 2 * TabFrac - QuatFrac;
    q[0] = 16'(round_half_up(cc * cy + ss * sy, sh));
    q[1] = 16'(round_half_up(sc * cy - cs * sy, sh));
    q[2] = 16'(round_half_up(cs * cy + sc * sy, sh));
    q[3] = 16'(round_half_up(cc * sy - ss * cy, sh));
    return q;
  endfunction

  function void note_angles(logic [7:0] r_deg, logic [7:0] p_deg, logic [7:0] y_deg);
    awaited_quats.push_back(angles_to_quat(r_deg, p_deg, y_deg));
  endfunction

  function void check_quat(quat_t got);
    string names[4];
    quat_t want;
    names = '{"quat_w", "quat_x", "quat_y", "quat_z"};
    if (awaited_quats.size() == 0) begin
      $error("result transfer with no input outstanding");
      mismatches++;
      return;
    end
    want = awaited_quats.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (got[i] !== want[i]) begin
        $error("%s: expected %0d, got %0d", names[i], $signed(want[i]), $signed(got[i]));
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return awaited_quats.size();
  endfunction
endclass

module euler_to_quaternion_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [eq_pkg::AngleWidth-1:0] roll_degrees = '0;
  logic [eq_pkg::AngleWidth-1:0] pitch_degrees = '0;
  logic [eq_pkg::AngleWidth-1:0] yaw_degrees = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  eq_pkg::quat_val_t quat_w;
  eq_pkg::quat_val_t quat_x;
  eq_pkg::quat_val_t quat_y;
  eq_pkg::quat_val_t quat_z;

  int send_idle_pct = 0;
  int take_stall_pct = 0;
  quat_ledger ledger = new();

  euler_to_quaternion dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .roll_degrees(roll_degrees),
    .pitch_degrees(pitch_degrees),
    .yaw_degrees(yaw_degrees),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ledger.check_quat({quat_z, quat_y, quat_x, quat_w});
    end
  end

  task automatic send_angles(logic [7:0] r, logic [7:0] p, logic [7:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    roll_degrees <= r;
    pitch_degrees <= p;
    yaw_degrees <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_angles(r, p, y);
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_angle();
    return ($urandom_range(99) < 80) ? 8'($urandom_range(180)) : 8'($urandom_range(255));
  endfunction

  initial begin
    #2_000_000;
    $display("euler_to_quaternion_tb: errors");
    $finish;
  end

  initial begin
    logic [7:0] corner[20][3];
    int idle_plan[4];
    int stall_plan[4];
    corner = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd180, 8'd180, 8'd180}, '{8'd255, 8'd255, 8'd255},
      '{8'd181, 8'd0, 8'd0}, '{8'd0, 8'd181, 8'd0}, '{8'd0, 8'd0, 8'd181},
      '{8'd90, 8'd0, 8'd0}, '{8'd0, 8'd90, 8'd0}, '{8'd0, 8'd0, 8'd90},
      '{8'd1, 8'd1, 8'd1}, '{8'd179, 8'd179, 8'd179}, '{8'd90, 8'd90, 8'd90},
      '{8'd45, 8'd30, 8'd60}, '{8'd170, 8'd85, 8'd128}, '{8'd127, 8'd128, 8'd200},
      '{8'd85, 8'd170, 8'd255}, '{8'd0, 8'd180, 8'd0}, '{8'd180, 8'd0, 8'd180},
      '{8'd64, 8'd32, 8'd16}, '{8'd8, 8'd4, 8'd2}
    };
    idle_plan = '{0, 85, 0, 32};
    stall_plan = '{0, 0, 85, 32};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (corner[i]) begin
      send_angles(corner[i][0], corner[i][1], corner[i][2]);
    end
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      take_stall_pct = stall_plan[ph];
      repeat (358) begin
        send_angles(random_angle(), random_angle(), random_angle());
      end
    end
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("euler_to_quaternion_tb: clean");
    end else begin
      $display("euler_to_quaternion_tb: errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/eq_pkg.sv
rtl/core/eq_trig_lookup.sv
rtl/core/euler_to_quaternion.sv
rtl/core/eq_checker.sv
tb/euler_to_quaternion_tb.sv
